// File: rtl/ggc_pkg.sv
`default_nettype none

package ggc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ROW_W        = 64;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int COL_W        = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } ggc_state_t;

    typedef struct packed {
        logic start;
        logic scan_step;
        logic finish;
    } ggc_cmd_t;

    typedef struct packed {
        logic first_vertex;
        logic full;
        logic scan_last;
        logic out_free;
    } ggc_status_t;

endpackage

`default_nettype wire

// File: rtl/ggc_ctrl.sv
`default_nettype none

module ggc_ctrl
    import ggc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire ggc_status_t status,
    output ggc_cmd_t         cmd
);

    ggc_state_t state_reg;
    ggc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.start     = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.finish    = 1'b0;
        in_stall      = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.first_vertex || status.full)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/ggc_dp.sv
`default_nettype none

module ggc_dp
    import ggc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ggc_cmd_t           cmd,
    output ggc_status_t             status,
    input  wire logic               new_graph,
    input  wire logic [ROW_W-1:0]   conflict_row,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [IDX_W-1:0]        vertex_index,
    output logic [COL_W-1:0]        color,
    output logic [CNT_W-1:0]        colors_used,
    output logic                    overflow
);

    logic [COL_W-1:0] mem [MAX_VERTICES];

    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] taken_reg, taken_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] vert_reg, vert_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             hit_reg, hit_next;
    logic [COL_W-1:0] rd_data_reg;

    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic             out_ovf_reg, out_ovf_next;

    logic [ROW_W-1:0] color_dec;
    logic [ROW_W-1:0] free_mask;
    logic [ROW_W-1:0] lowest_free;
    logic [IDX_W-1:0] free_pos;
    logic [COL_W-1:0] cand_col;
    logic [COL_W-1:0] new_col;
    logic             full;
    logic             do_write;

    assign full = (vert_reg >= CNT_W'(MAX_VERTICES));

    assign status.first_vertex = (vert_reg == '0);
    assign status.full         = full;
    assign status.scan_last    = (scan_reg == IDX_W'(vert_reg - CNT_W'(1)));
    assign status.out_free     = !out_valid_reg || !out_stall;

    // color c marks bit c-1 of the taken mask
    always_comb
    begin
        color_dec = '0;
        color_dec[IDX_W'(rd_data_reg - COL_W'(1))] = 1'b1;
    end

    // first free color: isolate lowest clear bit, then encode it
    assign free_mask   = ~taken_reg;
    assign lowest_free = free_mask & (~free_mask + ROW_W'(1));

    always_comb
    begin
        free_pos = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            if (lowest_free[i])
            begin
                free_pos = free_pos | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        if (free_mask == '0)
        begin
            cand_col = COL_W'(count_reg) + COL_W'(1);
        end
        else
        begin
            cand_col = COL_W'(free_pos) + COL_W'(1);
        end
        if (status.first_vertex)
        begin
            new_col = COL_W'(1);
        end
        else if (cand_col > COL_W'(count_reg))
        begin
            new_col = COL_W'(count_reg) + COL_W'(1);
        end
        else
        begin
            new_col = cand_col;
        end
    end

    assign do_write = cmd.finish && !full;

    always_comb
    begin
        row_next       = row_reg;
        scan_next      = scan_reg;
        vert_next      = vert_reg;
        count_next     = count_reg;
        hit_next       = cmd.scan_step && row_reg[scan_reg];
        taken_next     = taken_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_col_next   = out_col_reg;
        out_cnt_next   = out_cnt_reg;
        out_ovf_next   = out_ovf_reg;

        if (hit_reg && (rd_data_reg != '0))
        begin
            taken_next = taken_reg | color_dec;
        end

        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.start)
        begin
            row_next   = conflict_row;
            scan_next  = '0;
            taken_next = '0;
            if (new_graph)
            begin
                vert_next  = '0;
                count_next = CNT_W'(1);
            end
        end

        if (cmd.scan_step)
        begin
            scan_next = scan_reg + IDX_W'(1);
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            if (full)
            begin
                out_idx_next = '0;
                out_col_next = '0;
                out_cnt_next = count_reg;
                out_ovf_next = 1'b1;
            end
            else
            begin
                vert_next    = vert_reg + CNT_W'(1);
                out_idx_next = IDX_W'(vert_reg);
                out_col_next = new_col;
                out_ovf_next = 1'b0;
                if (new_col > COL_W'(count_reg))
                begin
                    count_next   = CNT_W'(new_col);
                    out_cnt_next = CNT_W'(new_col);
                end
                else
                begin
                    out_cnt_next = count_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vert_reg      <= '0;
            count_reg     <= CNT_W'(1);
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vert_reg      <= vert_next;
            count_reg     <= count_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        scan_reg    <= scan_next;
        taken_reg   <= taken_next;
        out_idx_reg <= out_idx_next;
        out_col_reg <= out_col_next;
        out_cnt_reg <= out_cnt_next;
        out_ovf_reg <= out_ovf_next;
    end

    // color store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[IDX_W'(vert_reg)] <= new_col;
        end
        rd_data_reg <= mem[scan_reg];
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = out_idx_reg;
    assign color        = out_col_reg;
    assign colors_used  = out_cnt_reg;
    assign overflow     = out_ovf_reg;

endmodule

`default_nettype wire

// File: rtl/greedy_graph_colorer_unit.sv
// flow: vertex n > 0 passes through CHECK, SCAN over the n stored colors, DRAIN and
// DONE; vertex 0 and overflow items go from CHECK straight to DONE
// a new item is taken only in IDLE, after the last one has left DONE; the pace is set
// by the serial read of the n stored colors through the single read port of the store
// reset: asynchronous active low; next vertex 0, color count 1, color store not cleared
`default_nettype none

module greedy_graph_colorer_unit
    import ggc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             new_graph,
    input  wire logic [ROW_W-1:0] conflict_row,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [IDX_W-1:0]      vertex_index,
    output logic [COL_W-1:0]      color,
    output logic [CNT_W-1:0]      colors_used,
    output logic                  overflow
);

    ggc_cmd_t    cmd;
    ggc_status_t status;

    ggc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ggc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .new_graph    (new_graph),
        .conflict_row (conflict_row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .vertex_index (vertex_index),
        .color        (color),
        .colors_used  (colors_used),
        .overflow     (overflow)
    );

endmodule

`default_nettype wire

// File: rtl/ggc_checker.sv
`default_nettype none

module ggc_checker
    import ggc_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire logic             new_graph,
    input wire logic [ROW_W-1:0] conflict_row,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic [IDX_W-1:0] vertex_index,
    input wire logic [COL_W-1:0] color,
    input wire logic [CNT_W-1:0] colors_used,
    input wire logic             overflow
);

    // a waiting item holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vertex_index) && $stable(color)
            && $stable(colors_used) && $stable(overflow))
        else $error("output item changed while stalled");

    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> color == '0 && vertex_index == '0)
        else $error("overflow item carries a color or index");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overflow |-> color != '0 && CNT_W'(color) <= colors_used)
        else $error("color outside the colors in use");

    a_first_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overflow && vertex_index == '0 |-> color == COL_W'(1))
        else $error("first vertex not given color one");

endmodule

bind greedy_graph_colorer_unit ggc_checker u_ggc_checker (.*);

`default_nettype wire

// File: dv/tb_greedy_graph_colorer_unit.sv
`timescale 1ns / 1ps

module tb_greedy_graph_colorer_unit;
    import ggc_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 850;

    typedef struct {
        logic [IDX_W-1:0] vertex_index;
        logic [COL_W-1:0] color;
        logic [CNT_W-1:0] colors_used;
        logic             overflow;
    } coloring_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic             new_graph;
    logic [ROW_W-1:0] conflict_row;
    logic             out_valid;
    logic             out_stall;
    logic [IDX_W-1:0] vertex_index;
    logic [COL_W-1:0] color;
    logic [CNT_W-1:0] colors_used;
    logic             overflow;

    // predictor state
    logic [COL_W-1:0] vertex_color_mem [MAX_VERTICES];
    int               next_vertex_idx;
    logic [CNT_W-1:0] colors_in_use;

    coloring_t expected_colorings[$];
    int        mismatches  = 0;
    int        cycle_count = 0;
    int        hold_cycles = 0;
    int        stall_left  = 0;
    bit        tx_idle_en  = 1'b0;
    bit        rx_idle_en  = 1'b0;

    greedy_graph_colorer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .new_graph    (new_graph),
        .conflict_row (conflict_row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .vertex_index (vertex_index),
        .color        (color),
        .colors_used  (colors_used),
        .overflow     (overflow)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void predict_coloring(input logic start, input logic [ROW_W-1:0] row);
        coloring_t        r;
        logic [63:0]      taken;
        logic [COL_W-1:0] pick;
        if (start)
        begin
            next_vertex_idx = 0;
            colors_in_use   = CNT_W'(1);
        end
        if (next_vertex_idx >= MAX_VERTICES)
        begin
            r.vertex_index = '0;
            r.color        = '0;
            r.colors_used  = colors_in_use;
            r.overflow     = 1'b1;
        end
        else
        begin
            if (next_vertex_idx == 0)
            begin
                pick = COL_W'(1);
            end
            else
            begin
                taken = '0;
                for (int j = 0; j < next_vertex_idx; j++)
                    if (row[j] && vertex_color_mem[j] != 0)
                        taken[IDX_W'(vertex_color_mem[j] - COL_W'(1))] = 1'b1;
                pick = colors_in_use + CNT_W'(1);
                for (int c = int'(colors_in_use); c >= 1; c--)
                    if (c <= 64 && !taken[c - 1])
                        pick = COL_W'(c);
                if (pick > colors_in_use)
                    colors_in_use = pick;
            end
            vertex_color_mem[next_vertex_idx[IDX_W-1:0]] = pick;
            r.vertex_index = next_vertex_idx[IDX_W-1:0];
            r.color        = pick;
            r.colors_used  = colors_in_use;
            r.overflow     = 1'b0;
            next_vertex_idx++;
        end
        expected_colorings.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        coloring_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_colorings.size() == 0)
            begin
                $error("result with no item pending: vertex_index %0d color %0d",
                       vertex_index, color);
                mismatches++;
            end
            else
            begin
                want = expected_colorings.pop_front();
                check_field("vertex_index", 8'(want.vertex_index), 8'(vertex_index));
                check_field("color", 8'(want.color), 8'(color));
                check_field("colors_used", 8'(want.colors_used), 8'(colors_used));
                check_field("overflow", 8'(want.overflow), 8'(overflow));
            end
        end
    end

    // receiver side: a long hold-off while hold_cycles is set, else random stalls if enabled
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall = 1'b1;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else if (rx_idle_en && $urandom_range(0, 99) < 25)
            begin
                out_stall  = 1'b1;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                         : $urandom_range(0, 2);
            end
            else
            begin
                out_stall = 1'b0;
            end
        end
    end

    function automatic logic [ROW_W-1:0] random_row();
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        logic [ROW_W-1:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            2, 3:    return a & b & c;
            4, 5:    return a | b;
            default: return a;
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_vertex(input logic start, input logic [ROW_W-1:0] row);
        in_valid     = 1'b1;
        new_graph    = start;
        conflict_row = row;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_coloring(start, row);
        @(negedge clk);
    endtask

    task automatic idle_sender();
        int n;
        if (!tx_idle_en)
            return;
        case ($urandom_range(0, 9))
            0:          n = $urandom_range(10, 60);
            1, 2, 3:    n = $urandom_range(1, 3);
            default:    n = 0;
        endcase
        if (n > 0)
        begin
            in_valid     = 1'b0;
            new_graph    = 1'($urandom_range(0, 1));
            conflict_row = random_row();
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic wait_for_drain();
        in_valid = 1'b0;
        while (expected_colorings.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed_coloring();
        // first item after reset without new_graph is vertex 0
        send_vertex(1'b0, '1);
        send_vertex(1'b0, 64'h1);
        send_vertex(1'b0, 64'h0);
        send_vertex(1'b0, 64'h6);
        // bits at or above the vertex index are ignored
        send_vertex(1'b0, 64'hFFFF_FFFF_FFFF_FFF0);
        // restart mid-graph, twice in a row
        send_vertex(1'b1, '1);
        send_vertex(1'b1, 64'h0);
        send_vertex(1'b0, 64'h0);
        send_vertex(1'b0, 64'h3);
        send_vertex(1'b0, 64'h5);
        send_vertex(1'b0, 64'h2);
        send_vertex(1'b0, 64'h8);
        wait_for_drain();
    endtask

    task automatic test_clique_overflow();
        // complete graph reaches color 64, then vertices beyond the bound
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int v = 0; v < MAX_VERTICES + 3; v++)
        begin
            idle_sender();
            send_vertex(v == 0, v < MAX_VERTICES ? '1 : random_row());
        end
        send_vertex(1'b1, '1);
        send_vertex(1'b0, '0);
        wait_for_drain();
    endtask

    task automatic test_backpressure();
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        hold_cycles = 400;
        for (int v = 0; v < 12; v++)
            send_vertex(v == 0, random_row());
        wait_for_drain();
    endtask

    task automatic test_random_graphs();
        int   size;
        int   sent;
        logic start;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       size = $urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 6);
                1, 2:    size = $urandom_range(17, MAX_VERTICES);
                default: size = $urandom_range(1, 16);
            endcase
            start = ($urandom_range(0, 19) != 0);
            for (int v = 0; v < size; v++)
            begin
                idle_sender();
                send_vertex(v == 0 ? start : ($urandom_range(0, 49) == 0), random_row());
                sent++;
            end
            if ($urandom_range(0, 7) == 0)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        new_graph    = 1'b0;
        conflict_row = '0;
        next_vertex_idx = 0;
        colors_in_use   = CNT_W'(1);
        for (int j = 0; j < MAX_VERTICES; j++)
            vertex_color_mem[j] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_coloring();
        test_clique_overflow();
        test_backpressure();
        test_random_graphs();

        in_valid = 1'b0;
        repeat (80) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
rtl/ggc_pkg.sv
rtl/ggc_ctrl.sv
rtl/ggc_dp.sv
rtl/greedy_graph_colorer_unit.sv
rtl/ggc_checker.sv
dv/tb_greedy_graph_colorer_unit.sv
